FILE: hw/rtl/imu_fp_pkg.sv
package imu_fp_pkg;

   localparam logic [7:0] HEADER_BYTE = 8'h55;
   localparam logic [7:0] TYPE_ACCEL  = 8'h51;
   localparam logic [7:0] TYPE_ANGLE  = 8'h53;

   localparam logic [13:0] ACCEL_SCALE = 14'd9800;
   localparam logic [13:0] ANGLE_SCALE = 14'd1800;
   localparam int          FRAC_BITS   = 15;

   // byte position of the checksum within the frame
   localparam logic [3:0] CHECK_POS = 4'd10;
   localparam logic [3:0] TYPE_POS  = 4'd1;
   localparam logic [3:0] DATA_POS  = 4'd2;
   localparam int         DATA_BYTES = 6;

   typedef enum logic [1:0] {
      KIND_ACCEL = 2'd0,
      KIND_ANGLE = 2'd1,
      KIND_OTHER = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] word0;
      logic [15:0] word1;
      logic [15:0] word2;
   } frame_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: hw/rtl/imu_fp_front.sv
module imu_fp_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_rx_byte,
   input  imu_fp_pkg::queue_status_type queue_status,
   output logic                        push,
   output imu_fp_pkg::frame_type       push_frame
);

   logic       header_ff, header_in;
   logic [3:0] count_ff, count_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] type_ff, type_in;
   logic [7:0] data_ff [imu_fp_pkg::DATA_BYTES];
   logic [7:0] data_in [imu_fp_pkg::DATA_BYTES];
   logic       accept;

   assign req_stall = queue_status.full;
   assign accept    = req_valid && !queue_status.full;

   always_comb begin
      header_in = header_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      type_in   = type_ff;
      push      = 1'b0;
      for (int i = 0; i < imu_fp_pkg::DATA_BYTES; i++) begin
         data_in[i] = data_ff[i];
         if (accept && header_ff && count_ff == imu_fp_pkg::DATA_POS + 4'(i)) begin
            data_in[i] = req_rx_byte;
         end
      end
      if (accept) begin
         if (!header_ff) begin
            if (req_rx_byte == imu_fp_pkg::HEADER_BYTE) begin
               header_in = 1'b1;
               count_in  = 4'd1;
               sum_in    = req_rx_byte;
            end
         end else if (count_ff == imu_fp_pkg::CHECK_POS) begin
            header_in = 1'b0;
            count_in  = 4'd0;
            push      = (sum_ff == req_rx_byte);
         end else begin
            count_in = count_ff + 4'd1;
            sum_in   = sum_ff + req_rx_byte;
            if (count_ff == imu_fp_pkg::TYPE_POS) begin
               type_in = req_rx_byte;
            end
         end
      end
   end

   always_comb begin
      case (type_ff)
         imu_fp_pkg::TYPE_ACCEL: push_frame.kind = imu_fp_pkg::KIND_ACCEL;
         imu_fp_pkg::TYPE_ANGLE: push_frame.kind = imu_fp_pkg::KIND_ANGLE;
         default:                push_frame.kind = imu_fp_pkg::KIND_OTHER;
      endcase
      push_frame.word0 = {data_ff[1], data_ff[0]};
      push_frame.word1 = {data_ff[3], data_ff[2]};
      push_frame.word2 = {data_ff[5], data_ff[4]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= 1'b0;
         count_ff  <= 4'd0;
      end else begin
         header_ff <= header_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      type_ff <= type_in;
      for (int i = 0; i < imu_fp_pkg::DATA_BYTES; i++) begin
         data_ff[i] <= data_in[i];
      end
   end

endmodule

FILE: hw/rtl/imu_fp_queue.sv
module imu_fp_queue #(
   parameter int DEPTH = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  imu_fp_pkg::frame_type        push_frame,
   input  logic                         pop,
   output imu_fp_pkg::frame_type        pop_frame,
   output imu_fp_pkg::queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   imu_fp_pkg::frame_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_frame    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_frame;
      end
   end

endmodule

FILE: hw/rtl/imu_fp_back.sv
module imu_fp_back (
   input  logic                         clock,
   input  logic                         reset,
   input  imu_fp_pkg::queue_status_type queue_status,
   output logic                         pop,
   input  imu_fp_pkg::frame_type        pop_frame,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_frame_kind,
   output logic signed [14:0]           rsp_accel_x,
   output logic signed [11:0]           rsp_roll_angle,
   output logic signed [11:0]           rsp_pitch_angle,
   output logic signed [11:0]           rsp_yaw_angle
);

   typedef enum logic [3:0] {
      B_IDLE  = 4'b0001,
      B_MUL   = 4'b0010,
      B_SHIFT = 4'b0100,
      B_EMIT  = 4'b1000
   } back_state_type;

   localparam logic [1:0] IDX_ROLL  = 2'd0;
   localparam logic [1:0] IDX_PITCH = 2'd1;

   back_state_type        state_ff, state_in;
   imu_fp_pkg::frame_type work_ff, work_in;
   logic [1:0]            idx_ff, idx_in;
   logic signed [30:0]    prod_ff, prod_in;
   logic signed [30:0]    biased;
   logic signed [15:0]    scaled;
   logic [15:0]           sel_word;
   logic [13:0]           scale;
   logic signed [14:0]    accel_ff, accel_in;
   logic signed [11:0]    roll_ff, roll_in;
   logic signed [11:0]    pitch_ff, pitch_in;
   logic signed [11:0]    yaw_ff, yaw_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            kind_out_ff, kind_out_in;
   logic signed [14:0]    accel_out_ff, accel_out_in;
   logic signed [11:0]    roll_out_ff, roll_out_in;
   logic signed [11:0]    pitch_out_ff, pitch_out_in;
   logic signed [11:0]    yaw_out_ff, yaw_out_in;
   logic                  out_free;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_frame_kind  = kind_out_ff;
   assign rsp_accel_x     = accel_out_ff;
   assign rsp_roll_angle  = roll_out_ff;
   assign rsp_pitch_angle = pitch_out_ff;
   assign rsp_yaw_angle   = yaw_out_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      case (idx_ff)
         IDX_ROLL:  sel_word = work_ff.word0;
         IDX_PITCH: sel_word = work_ff.word1;
         default:   sel_word = work_ff.word2;
      endcase
      scale   = (work_ff.kind == imu_fp_pkg::KIND_ACCEL) ? imu_fp_pkg::ACCEL_SCALE
                                                         : imu_fp_pkg::ANGLE_SCALE;
      prod_in = $signed(sel_word) * $signed({1'b0, scale});
      // truncate toward zero: bias negative products before the shift
      biased  = prod_ff + (prod_ff[30] ? 31'sd32767 : 31'sd0);
      scaled  = biased[30:imu_fp_pkg::FRAC_BITS];
   end

   always_comb begin
      state_in     = state_ff;
      work_in      = work_ff;
      idx_in       = idx_ff;
      accel_in     = accel_ff;
      roll_in      = roll_ff;
      pitch_in     = pitch_ff;
      yaw_in       = yaw_ff;
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_out_in  = kind_out_ff;
      accel_out_in = accel_out_ff;
      roll_out_in  = roll_out_ff;
      pitch_out_in = pitch_out_ff;
      yaw_out_in   = yaw_out_ff;
      case (state_ff)
         B_IDLE: begin
            if (!queue_status.empty) begin
               pop     = 1'b1;
               work_in = pop_frame;
               idx_in  = IDX_ROLL;
               if (pop_frame.kind == imu_fp_pkg::KIND_ACCEL ||
                   pop_frame.kind == imu_fp_pkg::KIND_ANGLE) begin
                  state_in = B_MUL;
               end else begin
                  state_in = B_EMIT;
               end
            end
         end
         B_MUL: begin
            state_in = B_SHIFT;
         end
         B_SHIFT: begin
            if (work_ff.kind == imu_fp_pkg::KIND_ACCEL) begin
               accel_in = scaled[14:0];
               state_in = B_EMIT;
            end else begin
               case (idx_ff)
                  IDX_ROLL:  roll_in  = scaled[11:0];
                  IDX_PITCH: pitch_in = scaled[11:0];
                  default:   yaw_in   = scaled[11:0];
               endcase
               if (idx_ff == IDX_ROLL || idx_ff == IDX_PITCH) begin
                  idx_in   = idx_ff + 2'd1;
                  state_in = B_MUL;
               end else begin
                  state_in = B_EMIT;
               end
            end
         end
         B_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_out_in  = work_ff.kind;
               accel_out_in = accel_ff;
               roll_out_in  = roll_ff;
               pitch_out_in = pitch_ff;
               yaw_out_in   = yaw_ff;
               state_in     = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
         accel_ff     <= '0;
         roll_ff      <= '0;
         pitch_ff     <= '0;
         yaw_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         accel_ff     <= accel_in;
         roll_ff      <= roll_in;
         pitch_ff     <= pitch_in;
         yaw_ff       <= yaw_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff      <= work_in;
      idx_ff       <= idx_in;
      prod_ff      <= prod_in;
      kind_out_ff  <= kind_out_in;
      accel_out_ff <= accel_out_in;
      roll_out_ff  <= roll_out_in;
      pitch_out_ff <= pitch_out_in;
      yaw_out_ff   <= yaw_out_in;
   end

endmodule

FILE: hw/rtl/imu_frame_parser.sv
// Decodes 11-byte inertial sensor frames from a serial byte stream, one byte per
// transfer on req_. A frame opens with 0x55; after the eleventh byte the 8-bit sum
// of bytes 0..9 is checked against byte 10 and a bad frame is dropped with no
// transfer on rsp_. A good frame yields one rsp_ transfer with its kind and the
// latched acceleration X and roll, pitch and yaw, updated first for type 0x51 or
// 0x53. The front accepts one byte every clock; req_stall rises only while the
// frame queue (QUEUE_DEPTH entries) is full. The back shares one multiplier and
// passes each scaled value through B_MUL and B_SHIFT (acceleration X, or roll,
// pitch and yaw for angle frames) before B_EMIT loads the result registers.
module imu_frame_parser #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_frame_kind,
   output logic signed [14:0] rsp_accel_x,
   output logic signed [11:0] rsp_roll_angle,
   output logic signed [11:0] rsp_pitch_angle,
   output logic signed [11:0] rsp_yaw_angle
);

   imu_fp_pkg::queue_status_type queue_status;
   imu_fp_pkg::frame_type        push_frame;
   imu_fp_pkg::frame_type        pop_frame;
   logic                         push;
   logic                         pop;

   imu_fp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_rx_byte  (req_rx_byte),
      .queue_status (queue_status),
      .push         (push),
      .push_frame   (push_frame)
   );

   imu_fp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (push_frame),
      .pop        (pop),
      .pop_frame  (pop_frame),
      .status     (queue_status)
   );

   imu_fp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_status    (queue_status),
      .pop             (pop),
      .pop_frame       (pop_frame),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_frame_kind  (rsp_frame_kind),
      .rsp_accel_x     (rsp_accel_x),
      .rsp_roll_angle  (rsp_roll_angle),
      .rsp_pitch_angle (rsp_pitch_angle),
      .rsp_yaw_angle   (rsp_yaw_angle)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !queue_status.full)
      else $error("frame pushed into full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !queue_status.empty)
      else $error("frame popped from empty queue");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_accel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_accel_x >= -15'sd9800 && rsp_accel_x <= 15'sd9799))
      else $error("acceleration out of range");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_roll_angle >= -12'sd1800 && rsp_roll_angle <= 12'sd1799 &&
                     rsp_pitch_angle >= -12'sd1800 && rsp_pitch_angle <= 12'sd1799 &&
                     rsp_yaw_angle >= -12'sd1800 && rsp_yaw_angle <= 12'sd1799))
      else $error("angle out of range");

endmodule

FILE: dv/imu_frame_checker.sv
`timescale 1ns / 1ps

module imu_frame_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [1:0]         rsp_frame_kind,
   input  logic signed [14:0] rsp_accel_x,
   input  logic signed [11:0] rsp_roll_angle,
   input  logic signed [11:0] rsp_pitch_angle,
   input  logic signed [11:0] rsp_yaw_angle,
   output int                 mismatches,
   output int                 pending
);

   localparam int FRAME_BYTES = int'(imu_fp_pkg::CHECK_POS) + 1;

   typedef struct packed {
      imu_fp_pkg::kind_type kind;
      logic [14:0]          accel;
      logic [11:0]          roll;
      logic [11:0]          pitch;
      logic [11:0]          yaw;
   } imu_sample_type;

   logic           in_frame;
   logic [3:0]     byte_idx;
   logic [7:0]     frame_bytes [0:10];
   logic [14:0]    accel_now;
   logic [11:0]    roll_now;
   logic [11:0]    pitch_now;
   logic [11:0]    yaw_now;
   imu_sample_type due_samples [$];
   imu_sample_type seen;
   imu_sample_type want;

   // little-endian int16 times gain over full scale, truncated toward zero
   function automatic int scaled_word(input int lo_pos, input int gain);
      logic signed [15:0] raw;
      raw = {frame_bytes[lo_pos + 1], frame_bytes[lo_pos]};
      return (int'(raw) * gain) / (1 << imu_fp_pkg::FRAC_BITS);
   endfunction

   function automatic string describe(input imu_sample_type s);
      return $sformatf("kind %0d accel %0d roll %0d pitch %0d yaw %0d", s.kind,
                       $signed(s.accel), $signed(s.roll), $signed(s.pitch), $signed(s.yaw));
   endfunction

   task automatic absorb_byte(input logic [7:0] b);
      logic [7:0]     sum;
      imu_sample_type s;
      if (!in_frame) begin
         if (b == imu_fp_pkg::HEADER_BYTE) begin
            frame_bytes[0] = b;
            byte_idx = 4'd1;
            in_frame = 1'b1;
         end
         return;
      end
      frame_bytes[byte_idx] = b;
      byte_idx = byte_idx + 4'd1;
      if (int'(byte_idx) < FRAME_BYTES) return;
      in_frame = 1'b0;
      byte_idx = '0;
      sum = '0;
      for (int i = 0; i < FRAME_BYTES - 1; i++) sum = sum + frame_bytes[i];
      if (sum != frame_bytes[imu_fp_pkg::CHECK_POS]) return;
      case (frame_bytes[imu_fp_pkg::TYPE_POS])
         imu_fp_pkg::TYPE_ACCEL: begin
            accel_now = 15'(scaled_word(int'(imu_fp_pkg::DATA_POS),
                                        int'(imu_fp_pkg::ACCEL_SCALE)));
            s.kind = imu_fp_pkg::KIND_ACCEL;
         end
         imu_fp_pkg::TYPE_ANGLE: begin
            roll_now  = 12'(scaled_word(int'(imu_fp_pkg::DATA_POS),
                                        int'(imu_fp_pkg::ANGLE_SCALE)));
            pitch_now = 12'(scaled_word(int'(imu_fp_pkg::DATA_POS) + 2,
                                        int'(imu_fp_pkg::ANGLE_SCALE)));
            yaw_now   = 12'(scaled_word(int'(imu_fp_pkg::DATA_POS) + 4,
                                        int'(imu_fp_pkg::ANGLE_SCALE)));
            s.kind = imu_fp_pkg::KIND_ANGLE;
         end
         default: begin
            s.kind = imu_fp_pkg::KIND_OTHER;
         end
      endcase
      s.accel = accel_now;
      s.roll  = roll_now;
      s.pitch = pitch_now;
      s.yaw   = yaw_now;
      due_samples.push_back(s);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         in_frame = 1'b0;
         byte_idx = '0;
         accel_now = '0;
         roll_now = '0;
         pitch_now = '0;
         yaw_now = '0;
         due_samples.delete();
         mismatches = 0;
      end else begin
         if (req_valid && !req_stall) absorb_byte(req_rx_byte);
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_frame_kind, rsp_accel_x, rsp_roll_angle, rsp_pitch_angle,
                    rsp_yaw_angle};
            if (due_samples.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result with none expected: %s", $realtime, describe(seen));
            end else begin
               want = due_samples.pop_front();
               if (seen !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: mismatch\n   expected %s\n   actual   %s", $realtime,
                              describe(want), describe(seen));
               end
            end
         end
      end
      pending = due_samples.size();
   end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int FRAME_BYTES  = int'(imu_fp_pkg::CHECK_POS) + 1;
   localparam int RANDOM_BYTES = 600;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_LIMIT  = 2000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [7:0]         req_rx_byte;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_frame_kind;
   logic signed [14:0] rsp_accel_x;
   logic signed [11:0] rsp_roll_angle;
   logic signed [11:0] rsp_pitch_angle;
   logic signed [11:0] rsp_yaw_angle;

   int mismatches;
   int pending;
   int cycles;
   int bytes_sent;
   bit calm;

   imu_frame_parser dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_frame_kind  (rsp_frame_kind),
      .rsp_accel_x     (rsp_accel_x),
      .rsp_roll_angle  (rsp_roll_angle),
      .rsp_pitch_angle (rsp_pitch_angle),
      .rsp_yaw_angle   (rsp_yaw_angle)
   );

   imu_frame_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_frame_kind  (rsp_frame_kind),
      .rsp_accel_x     (rsp_accel_x),
      .rsp_roll_angle  (rsp_roll_angle),
      .rsp_pitch_angle (rsp_pitch_angle),
      .rsp_yaw_angle   (rsp_yaw_angle),
      .mismatches      (mismatches),
      .pending         (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      cycles = 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver: random stall before each transfer
   initial begin
      int hold;
      rsp_stall = 1'b0;
      forever begin
         hold = calm ? 0 : $urandom_range(0, 11);
         repeat (hold) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 11);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [7:0] type_byte, input logic [15:0] w0,
                             input logic [15:0] w1, input logic [15:0] w2, input bit spoil);
      logic [7:0] fr [0:10];
      logic [7:0] sum;
      fr[0] = imu_fp_pkg::HEADER_BYTE;
      fr[1] = type_byte;
      {fr[3], fr[2]} = w0;
      {fr[5], fr[4]} = w1;
      {fr[7], fr[6]} = w2;
      fr[8] = 8'($urandom);
      fr[9] = 8'($urandom);
      sum = '0;
      for (int i = 0; i < FRAME_BYTES - 1; i++) sum = sum + fr[i];
      fr[10] = spoil ? sum ^ 8'($urandom_range(1, 255)) : sum;
      for (int i = 0; i < FRAME_BYTES; i++) send_byte(fr[i]);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 15))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'hFFFF;
         3: return 16'h0000;
         4: return 16'h8001;
         5: return {imu_fp_pkg::HEADER_BYTE, imu_fp_pkg::HEADER_BYTE};
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int frames;
      int pick;
      int waited;
      logic [7:0] type_byte;
      logic [7:0] noise;
      req_valid = 1'b0;
      req_rx_byte = '0;
      reset = 1'b1;
      calm = 1'b0;
      bytes_sent = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // bytes ahead of any header, then frames at the extremes and a spoiled one
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(imu_fp_pkg::TYPE_ANGLE, 16'h7FFF, 16'h8000,
                 {imu_fp_pkg::HEADER_BYTE, imu_fp_pkg::HEADER_BYTE}, 1'b0);
      send_frame(imu_fp_pkg::TYPE_ACCEL, 16'h8000, 16'hFFFF, 16'h0001, 1'b0);
      send_frame(8'h00, 16'h1234, 16'hFEDC, 16'h0F0F, 1'b1);
      send_frame(imu_fp_pkg::TYPE_ACCEL, 16'h7FFF, 16'h0000, 16'h0000, 1'b0);
      wait_for_results();

      bytes_sent = 0;
      frames = 0;
      while (bytes_sent < RANDOM_BYTES) begin
         if ($urandom_range(0, 11) == 0) calm = !calm;
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            repeat ($urandom_range(1, 4)) begin
               do noise = 8'($urandom); while (noise == imu_fp_pkg::HEADER_BYTE);
               send_byte(noise);
            end
         end else if (pick < 12) begin
            send_byte(imu_fp_pkg::HEADER_BYTE);
            repeat (FRAME_BYTES - 1) send_byte(8'($urandom));
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 40) type_byte = imu_fp_pkg::TYPE_ACCEL;
            else if (pick < 80) type_byte = imu_fp_pkg::TYPE_ANGLE;
            else type_byte = 8'($urandom);
            send_frame(type_byte, pick_word(), pick_word(), pick_word(),
                       $urandom_range(0, 9) == 0);
         end
         frames++;
         if (frames % 40 == 39) wait_for_results();
      end

      @(negedge clock);
      req_valid <= 1'b0;
      waited = 0;
      while (pending != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (40) @(negedge clock);
      if (pending != 0) $display("%0d expected results never arrived", pending);
      if (mismatches == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
